FILE: src/terminal_escape_key_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// terminal escape key decoder: assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef TERMINAL_ESCAPE_KEY_DECODER_TOP_DEFINES_SVH
`define TERMINAL_ESCAPE_KEY_DECODER_TOP_DEFINES_SVH

// same-cycle implication
`define TEKD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TEKD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tekd_pkg.sv
// ----------------------------------------------------------------------------
// tekd_pkg
// phase codes, event kinds and fixed widths of the escape key decoder
// ----------------------------------------------------------------------------
package tekd_pkg;

    localparam int PTR_W  = 16;
    localparam int KIND_W = 5;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ESC   = 3'd1,
        PH_INTRO = 3'd2,
        PH_DIGIT = 3'd3,
        PH_MOUSE = 3'd4
    } phase_t;

    typedef logic [KIND_W-1:0] kind_t;

    localparam kind_t KIND_PLAIN       = 5'd0;
    localparam kind_t KIND_ESC         = 5'd1;
    localparam kind_t KIND_UP          = 5'd2;
    localparam kind_t KIND_DOWN        = 5'd3;
    localparam kind_t KIND_RIGHT       = 5'd4;
    localparam kind_t KIND_LEFT        = 5'd5;
    localparam kind_t KIND_HOME        = 5'd6;
    localparam kind_t KIND_END         = 5'd7;
    localparam kind_t KIND_DELETE      = 5'd8;
    localparam kind_t KIND_PAGE_UP     = 5'd9;
    localparam kind_t KIND_PAGE_DOWN   = 5'd10;
    localparam kind_t KIND_LEFT_DOWN   = 5'd11;
    localparam kind_t KIND_LEFT_UP     = 5'd12;
    localparam kind_t KIND_LEFT_DRAG   = 5'd13;
    localparam kind_t KIND_MID_DOWN    = 5'd14;
    localparam kind_t KIND_MID_UP      = 5'd15;
    localparam kind_t KIND_MID_DRAG    = 5'd16;
    localparam kind_t KIND_RIGHT_DOWN  = 5'd17;
    localparam kind_t KIND_RIGHT_UP    = 5'd18;
    localparam kind_t KIND_RIGHT_DRAG  = 5'd19;
    localparam kind_t KIND_SCROLL_UP   = 5'd20;
    localparam kind_t KIND_SCROLL_DOWN = 5'd21;
    localparam kind_t KIND_MOVE        = 5'd22;

    localparam logic [7:0] CH_ESC    = 8'd27;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_THREE  = 8'h33;
    localparam logic [7:0] CH_FIVE   = 8'h35;
    localparam logic [7:0] CH_SIX    = 8'h36;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_D      = 8'h44;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_F      = 8'h46;
    localparam logic [7:0] CH_UPPER_M = 8'h4D;
    localparam logic [7:0] CH_LOWER_M = 8'h6D;

    localparam logic [7:0] BTN_LEFT       = 8'd0;
    localparam logic [7:0] BTN_MID        = 8'd1;
    localparam logic [7:0] BTN_RIGHT      = 8'd2;
    localparam logic [7:0] BTN_LEFT_DRAG  = 8'd32;
    localparam logic [7:0] BTN_MID_DRAG   = 8'd33;
    localparam logic [7:0] BTN_RIGHT_DRAG = 8'd34;
    localparam logic [7:0] BTN_MOVE       = 8'd35;
    localparam logic [7:0] BTN_WHEEL_UP   = 8'd64;
    localparam logic [7:0] BTN_WHEEL_DN   = 8'd65;

endpackage

FILE: src/terminal_escape_key_decoder_top.sv
// ----------------------------------------------------------------------------
// terminal_escape_key_decoder_top
// turns a terminal byte stream into key and sgr mouse events
// ----------------------------------------------------------------------------
// usage
//   input channel s_*: one beat is a received byte or a read timeout
//   (s_is_timeout high, s_data_byte ignored). output channel m_*: one beat
//   per finished key or mouse event; bytes inside an open escape sequence
//   give no beat. pointer_x/pointer_y carry the stored mouse position.
//   path: an accepted beat is held in the input register while the decode
//   runs, and its event is then loaded into the output register (m_valid).
//   throughput: 1 beat per cycle while m_ready is high; decoder state and
//   output register update in the same cycle, so no bubble between beats.
//   stall: while m_ready is low with an event waiting, the decode of the
//   held input beat waits; s_ready drops once the input register is full.
//   reset: synchronous active-low aresetn empties both registers and puts
//   the decoder back in idle with the stored position at zero.
// ----------------------------------------------------------------------------
module terminal_escape_key_decoder_top
    import tekd_pkg::*;
#(
    parameter int MAX_MOUSE_BYTES = 29,
    parameter int COORD_BITS      = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_is_timeout,
    input  logic [7:0]         s_data_byte,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [KIND_W-1:0]  m_event_kind,
    output logic [7:0]         m_key_byte,
    output logic [PTR_W-1:0]   m_pointer_x,
    output logic [PTR_W-1:0]   m_pointer_y
);

    localparam int MB_W = $clog2(MAX_MOUSE_BYTES + 1);
    localparam int CW   = COORD_BITS;

    function automatic logic [CW-1:0] coord_acc(input logic [CW-1:0] acc,
                                                input logic [3:0] d);
        logic [CW+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + (CW+4)'(d);
        coord_acc = (v > (CW+4)'({CW{1'b1}})) ? {CW{1'b1}} : v[CW-1:0];
    endfunction

    function automatic logic [7:0] btn_acc(input logic [7:0] acc, input logic [3:0] d);
        logic [11:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + 12'(d);
        btn_acc = (v > 12'd255) ? 8'hFF : v[7:0];
    endfunction

    // input register
    logic         in_valid_reg, in_valid_next;
    logic         is_timeout_reg;
    logic [7:0]   data_byte_reg;

    // decoder state
    phase_t       phase_reg, phase_next;
    logic [7:0]   intro_byte_reg, intro_byte_next;
    logic [7:0]   digit_byte_reg, digit_byte_next;
    logic [1:0]   field_index_reg, field_index_next;
    logic [2:0]   digits_seen_reg, digits_seen_next;
    logic         parse_halted_reg, parse_halted_next;
    logic [7:0]   button_code_reg, button_code_next;
    logic [CW-1:0] column_acc_reg, column_acc_next;
    logic [CW-1:0] row_acc_reg, row_acc_next;
    logic [MB_W-1:0] mouse_bytes_reg, mouse_bytes_next;
    logic [CW-1:0] mouse_col_reg, mouse_col_next;
    logic [CW-1:0] mouse_row_reg, mouse_row_next;

    // output register
    logic         m_valid_reg, m_valid_next;
    kind_t        kind_reg;
    logic [7:0]   key_reg;
    logic [PTR_W-1:0] ptr_x_reg, ptr_y_reg;

    logic         advance;
    logic         emit;
    kind_t        kind;
    logic [7:0]   key;

    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        logic        is_digit;
        logic [3:0]  dval;
        logic        is_term;
        logic        fin;
        logic        down;
        logic        up;
        logic [1:0]  u_fi;
        logic [2:0]  u_ds;
        logic        u_halt;
        logic [7:0]  u_bc;
        logic [CW-1:0] u_col;
        logic [CW-1:0] u_row;
        logic [MB_W-1:0] mb_inc;
        kind_t       fin_kind;

        is_digit = (data_byte_reg >= CH_ZERO) && (data_byte_reg <= CH_NINE);
        dval     = 4'(data_byte_reg - CH_ZERO);
        is_term  = (data_byte_reg == CH_UPPER_M) || (data_byte_reg == CH_LOWER_M);
        down     = !is_timeout_reg && (data_byte_reg == CH_UPPER_M);
        up       = !is_timeout_reg && (data_byte_reg == CH_LOWER_M);
        mb_inc   = mouse_bytes_reg + 1'b1;

        // mouse field parse for a non-terminator byte
        u_fi   = field_index_reg;
        u_ds   = digits_seen_reg;
        u_halt = parse_halted_reg;
        u_bc   = button_code_reg;
        u_col  = column_acc_reg;
        u_row  = row_acc_reg;
        if (!is_timeout_reg && !is_term && !parse_halted_reg) begin
            if (is_digit) begin
                unique case (field_index_reg)
                    2'd0:    u_bc  = btn_acc(button_code_reg, dval);
                    2'd1:    u_col = coord_acc(column_acc_reg, dval);
                    default: u_row = coord_acc(row_acc_reg, dval);
                endcase
                if (digits_seen_reg != 3'd7) begin
                    u_ds = digits_seen_reg + 3'd1;
                end
            end else if (data_byte_reg == CH_SEMI && digits_seen_reg != 3'd0 &&
                         field_index_reg < 2'd2) begin
                u_fi = field_index_reg + 2'd1;
                u_ds = 3'd0;
            end else begin
                u_halt = 1'b1;
            end
        end

        // report close
        fin_kind = KIND_ESC;
        if (u_fi != 2'd0 || u_ds != 3'd0) begin
            unique case (u_bc)
                BTN_LEFT:       fin_kind = down ? KIND_LEFT_DOWN :
                                           (up ? KIND_LEFT_UP : KIND_ESC);
                BTN_MID:        fin_kind = down ? KIND_MID_DOWN :
                                           (up ? KIND_MID_UP : KIND_ESC);
                BTN_RIGHT:      fin_kind = down ? KIND_RIGHT_DOWN :
                                           (up ? KIND_RIGHT_UP : KIND_ESC);
                BTN_LEFT_DRAG:  fin_kind = down ? KIND_LEFT_DRAG : KIND_ESC;
                BTN_MID_DRAG:   fin_kind = down ? KIND_MID_DRAG : KIND_ESC;
                BTN_RIGHT_DRAG: fin_kind = down ? KIND_RIGHT_DRAG : KIND_ESC;
                BTN_MOVE:       fin_kind = KIND_MOVE;
                BTN_WHEEL_UP:   fin_kind = KIND_SCROLL_UP;
                BTN_WHEEL_DN:   fin_kind = KIND_SCROLL_DOWN;
                default:        fin_kind = KIND_ESC;
            endcase
        end

        phase_next        = phase_reg;
        intro_byte_next   = intro_byte_reg;
        digit_byte_next   = digit_byte_reg;
        field_index_next  = field_index_reg;
        digits_seen_next  = digits_seen_reg;
        parse_halted_next = parse_halted_reg;
        button_code_next  = button_code_reg;
        column_acc_next   = column_acc_reg;
        row_acc_next      = row_acc_reg;
        mouse_bytes_next  = mouse_bytes_reg;
        mouse_col_next    = mouse_col_reg;
        mouse_row_next    = mouse_row_reg;
        emit = 1'b0;
        kind = KIND_ESC;
        key  = 8'd0;
        fin  = 1'b0;

        unique case (phase_reg)
            PH_ESC: begin
                if (is_timeout_reg) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end else begin
                    intro_byte_next = data_byte_reg;
                    phase_next      = PH_INTRO;
                end
            end
            PH_INTRO: begin
                if (is_timeout_reg) begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                end else if (intro_byte_reg == CH_LBRACK && is_digit) begin
                    digit_byte_next = data_byte_reg;
                    phase_next      = PH_DIGIT;
                end else if (intro_byte_reg == CH_LBRACK && data_byte_reg == CH_LT) begin
                    field_index_next  = 2'd0;
                    digits_seen_next  = 3'd0;
                    parse_halted_next = 1'b0;
                    button_code_next  = 8'd0;
                    column_acc_next   = '0;
                    row_acc_next      = '0;
                    mouse_bytes_next  = '0;
                    phase_next        = PH_MOUSE;
                end else begin
                    emit       = 1'b1;
                    phase_next = PH_IDLE;
                    if (intro_byte_reg == CH_LBRACK) begin
                        unique case (data_byte_reg)
                            CH_A:    kind = KIND_UP;
                            CH_B:    kind = KIND_DOWN;
                            CH_C:    kind = KIND_RIGHT;
                            CH_D:    kind = KIND_LEFT;
                            CH_H:    kind = KIND_HOME;
                            CH_F:    kind = KIND_END;
                            default: kind = KIND_ESC;
                        endcase
                    end else if (intro_byte_reg == CH_O) begin
                        if (data_byte_reg == CH_H) begin
                            kind = KIND_HOME;
                        end else if (data_byte_reg == CH_F) begin
                            kind = KIND_END;
                        end
                    end
                end
            end
            PH_DIGIT: begin
                if (!is_timeout_reg && data_byte_reg == CH_TILDE) begin
                    if (digit_byte_reg == CH_THREE) begin
                        kind = KIND_DELETE;
                    end else if (digit_byte_reg == CH_FIVE) begin
                        kind = KIND_PAGE_UP;
                    end else if (digit_byte_reg == CH_SIX) begin
                        kind = KIND_PAGE_DOWN;
                    end
                end
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
            PH_MOUSE: begin
                field_index_next  = u_fi;
                digits_seen_next  = u_ds;
                parse_halted_next = u_halt;
                button_code_next  = u_bc;
                column_acc_next   = u_col;
                row_acc_next      = u_row;
                if (is_timeout_reg) begin
                    fin = 1'b1;
                end else begin
                    mouse_bytes_next = mb_inc;
                    fin = is_term || (mb_inc >= MB_W'(MAX_MOUSE_BYTES));
                end
                if (fin) begin
                    emit       = 1'b1;
                    kind       = fin_kind;
                    phase_next = PH_IDLE;
                    if (u_fi == 2'd2 && u_ds != 3'd0) begin
                        mouse_col_next = u_col;
                        mouse_row_next = u_row;
                    end
                end
            end
            default: begin
                phase_next = PH_IDLE;
                if (is_timeout_reg) begin
                    kind = KIND_PLAIN;
                    emit = 1'b1;
                end else if (data_byte_reg == CH_ESC) begin
                    phase_next = PH_ESC;
                end else begin
                    kind = KIND_PLAIN;
                    key  = data_byte_reg;
                    emit = 1'b1;
                end
            end
        endcase
    end

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (advance && emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            phase_reg        <= PH_IDLE;
            intro_byte_reg   <= 8'd0;
            digit_byte_reg   <= 8'd0;
            field_index_reg  <= 2'd0;
            digits_seen_reg  <= 3'd0;
            parse_halted_reg <= 1'b0;
            button_code_reg  <= 8'd0;
            column_acc_reg   <= '0;
            row_acc_reg      <= '0;
            mouse_bytes_reg  <= '0;
            mouse_col_reg    <= '0;
            mouse_row_reg    <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            if (advance) begin
                phase_reg        <= phase_next;
                intro_byte_reg   <= intro_byte_next;
                digit_byte_reg   <= digit_byte_next;
                field_index_reg  <= field_index_next;
                digits_seen_reg  <= digits_seen_next;
                parse_halted_reg <= parse_halted_next;
                button_code_reg  <= button_code_next;
                column_acc_reg   <= column_acc_next;
                row_acc_reg      <= row_acc_next;
                mouse_bytes_reg  <= mouse_bytes_next;
                mouse_col_reg    <= mouse_col_next;
                mouse_row_reg    <= mouse_row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            is_timeout_reg <= s_is_timeout;
            data_byte_reg  <= s_data_byte;
        end
        if (advance && emit) begin
            kind_reg  <= kind;
            key_reg   <= key;
            ptr_x_reg <= PTR_W'(mouse_col_next);
            ptr_y_reg <= PTR_W'(mouse_row_next);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_kind = kind_reg;
    assign m_key_byte   = key_reg;
    assign m_pointer_x  = ptr_x_reg;
    assign m_pointer_y  = ptr_y_reg;

endmodule

FILE: src/tekd_checker.sv
// ----------------------------------------------------------------------------
// tekd_checker
// port-level checks on the escape key decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "terminal_escape_key_decoder_top_defines.svh"

module tekd_checker
    import tekd_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_valid,
    input logic              m_ready,
    input logic [KIND_W-1:0] m_event_kind,
    input logic [7:0]        m_key_byte,
    input logic [PTR_W-1:0]  m_pointer_x,
    input logic [PTR_W-1:0]  m_pointer_y
);

    // stalled result beat holds
    `TEKD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_event_kind) && $stable(m_key_byte) && $stable(m_pointer_x) && $stable(m_pointer_y), "result beat changed while stalled")

    // event kind stays in the defined range
    `TEKD_ASSERT_NOW(a_kind_range, aclk, aresetn, m_valid, m_event_kind <= KIND_MOVE, "event kind out of range")

    // only a plain beat carries a key byte
    `TEKD_ASSERT_NOW(a_key_zero, aclk, aresetn, m_valid && m_event_kind != KIND_PLAIN, m_key_byte == 8'd0, "key byte set on a non-plain event")

    // esc always opens a sequence, never passes through
    `TEKD_ASSERT_NOW(a_no_plain_esc, aclk, aresetn, m_valid && m_event_kind == KIND_PLAIN, m_key_byte != CH_ESC, "esc passed through as a plain byte")

endmodule

bind terminal_escape_key_decoder_top tekd_checker u_tekd_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_event_kind (m_event_kind),
    .m_key_byte   (m_key_byte),
    .m_pointer_x  (m_pointer_x),
    .m_pointer_y  (m_pointer_y)
);

FILE: tb/tb_terminal_escape_key_decoder_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_terminal_escape_key_decoder_top
// self-checking bench for the terminal escape key decoder: a short table of
// directed beats, then random key and sgr mouse sequences with noise, run
// through a bit-level predictor; every output beat is compared in order
// ----------------------------------------------------------------------------
module tb_terminal_escape_key_decoder_top;
    import tekd_pkg::*;

    localparam int REPORT_MAX  = 29;
    localparam int COORD_MAX   = (1 << PTR_W) - 1;
    localparam int TYPE_MAX    = 255;
    localparam int RAND_BEATS  = 1850;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [7:0] NO_TERM = 8'h00;

    typedef struct packed {
        kind_t            kind;
        logic [7:0]       key;
        logic [PTR_W-1:0] px;
        logic [PTR_W-1:0] py;
    } key_event_t;

    typedef struct packed {
        logic       tmo;
        logic [7:0] data;
        logic       typed;
        key_event_t ev;
    } dir_row_t;

    logic             aclk;
    logic             aresetn;
    logic             s_valid;
    logic             s_ready;
    logic             s_is_timeout;
    logic [7:0]       s_data_byte;
    logic             m_valid;
    logic             m_ready;
    logic [KIND_W-1:0] m_event_kind;
    logic [7:0]       m_key_byte;
    logic [PTR_W-1:0] m_pointer_x;
    logic [PTR_W-1:0] m_pointer_y;

    terminal_escape_key_decoder_top #(
        .MAX_MOUSE_BYTES(REPORT_MAX),
        .COORD_BITS     (PTR_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_is_timeout (s_is_timeout),
        .s_data_byte  (s_data_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_kind (m_event_kind),
        .m_key_byte   (m_key_byte),
        .m_pointer_x  (m_pointer_x),
        .m_pointer_y  (m_pointer_y)
    );

    // decoder state copy
    phase_t           dec_phase;
    logic [7:0]       intro_q;
    logic [7:0]       digit_q;
    logic [1:0]       field_sel;
    logic [2:0]       digit_count;
    logic             parse_stop;
    logic [7:0]       btn_acc;
    logic [PTR_W-1:0] col_acc;
    logic [PTR_W-1:0] row_acc;
    logic [4:0]       report_len;
    logic [PTR_W-1:0] ptr_col;
    logic [PTR_W-1:0] ptr_row;

    key_event_t pending_events[$];
    int         err_count;
    int         beats_sent;
    int         cycle_count;
    int         send_idle_pct;
    int         recv_idle_pct;

    localparam int DIR_ROWS = 39;
    localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
        '{1'b0, 8'h00,     1'b1, '{KIND_PLAIN, 8'h00, 16'd0, 16'd0}},
        '{1'b0, 8'hFF,     1'b1, '{KIND_PLAIN, 8'hFF, 16'd0, 16'd0}},
        '{1'b1, 8'hA5,     1'b1, '{KIND_PLAIN, 8'h00, 16'd0, 16'd0}},
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b1, 8'h5A,     1'b1, '{KIND_ESC, 8'h00, 16'd0, 16'd0}},
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_LBRACK, 1'b0, '0},
        '{1'b0, CH_A,      1'b0, '0},
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_O,      1'b0, '0},
        '{1'b0, CH_F,      1'b0, '0},
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_LBRACK, 1'b0, '0},
        '{1'b0, CH_THREE,  1'b0, '0},
        '{1'b0, CH_TILDE,  1'b0, '0},
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_LBRACK, 1'b0, '0},
        '{1'b0, CH_SIX,    1'b0, '0},
        '{1'b1, 8'h00,     1'b1, '{KIND_ESC, 8'h00, 16'd0, 16'd0}},
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_LBRACK, 1'b0, '0},
        '{1'b0, 8'h5A,     1'b1, '{KIND_ESC, 8'h00, 16'd0, 16'd0}},
        // scroll down with a saturating column
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_LBRACK, 1'b0, '0},
        '{1'b0, CH_LT,     1'b0, '0},
        '{1'b0, CH_SIX,    1'b0, '0},
        '{1'b0, CH_FIVE,   1'b0, '0},
        '{1'b0, CH_SEMI,   1'b0, '0},
        '{1'b0, CH_NINE,   1'b0, '0},
        '{1'b0, CH_NINE,   1'b0, '0},
        '{1'b0, CH_NINE,   1'b0, '0},
        '{1'b0, CH_NINE,   1'b0, '0},
        '{1'b0, CH_NINE,   1'b0, '0},
        '{1'b0, CH_SEMI,   1'b0, '0},
        '{1'b0, CH_SIX,    1'b0, '0},
        '{1'b0, CH_UPPER_M, 1'b0, '0},
        // missing type
        '{1'b0, CH_ESC,    1'b0, '0},
        '{1'b0, CH_LBRACK, 1'b0, '0},
        '{1'b0, CH_LT,     1'b0, '0}
    };

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [PTR_W-1:0] sat_acc(input logic [PTR_W-1:0] acc,
                                                 input logic [7:0] d, input int lim);
        int v;
        v = int'(acc) * 10 + int'(d);
        if (v > lim) v = lim;
        return PTR_W'(v);
    endfunction

    function automatic kind_t close_report(input logic [7:0] term);
        bit    dn;
        bit    up;
        kind_t k;
        dn = (term == CH_UPPER_M);
        up = (term == CH_LOWER_M);
        k  = KIND_ESC;
        if (field_sel == 2'd2 && digit_count != 3'd0) begin
            ptr_col = col_acc;
            ptr_row = row_acc;
        end
        if (field_sel != 2'd0 || digit_count != 3'd0) begin
            case (btn_acc)
                BTN_LEFT:       k = dn ? KIND_LEFT_DOWN  : (up ? KIND_LEFT_UP  : KIND_ESC);
                BTN_MID:        k = dn ? KIND_MID_DOWN   : (up ? KIND_MID_UP   : KIND_ESC);
                BTN_RIGHT:      k = dn ? KIND_RIGHT_DOWN : (up ? KIND_RIGHT_UP : KIND_ESC);
                BTN_LEFT_DRAG:  k = dn ? KIND_LEFT_DRAG  : KIND_ESC;
                BTN_MID_DRAG:   k = dn ? KIND_MID_DRAG   : KIND_ESC;
                BTN_RIGHT_DRAG: k = dn ? KIND_RIGHT_DRAG : KIND_ESC;
                BTN_MOVE:       k = KIND_MOVE;
                BTN_WHEEL_UP:   k = KIND_SCROLL_UP;
                BTN_WHEEL_DN:   k = KIND_SCROLL_DOWN;
                default:        k = KIND_ESC;
            endcase
        end
        return k;
    endfunction

    function automatic bit decode_beat(input bit tmo, input logic [7:0] b,
                                       output key_event_t ev);
        bit         fire;
        kind_t      k;
        logic [7:0] key;
        logic [7:0] d;
        fire = 1'b0;
        k    = KIND_ESC;
        key  = 8'h00;
        d    = b - CH_ZERO;
        case (dec_phase)
            PH_ESC: begin
                if (tmo) begin
                    fire = 1'b1;
                    dec_phase = PH_IDLE;
                end else begin
                    intro_q = b;
                    dec_phase = PH_INTRO;
                end
            end
            PH_INTRO: begin
                if (tmo) begin
                    fire = 1'b1;
                    dec_phase = PH_IDLE;
                end else if (intro_q == CH_LBRACK && b >= CH_ZERO && b <= CH_NINE) begin
                    digit_q = b;
                    dec_phase = PH_DIGIT;
                end else if (intro_q == CH_LBRACK && b == CH_LT) begin
                    field_sel = 2'd0;
                    digit_count = 3'd0;
                    parse_stop = 1'b0;
                    btn_acc = 8'd0;
                    col_acc = '0;
                    row_acc = '0;
                    report_len = 5'd0;
                    dec_phase = PH_MOUSE;
                end else begin
                    if (intro_q == CH_LBRACK) begin
                        case (b)
                            CH_A:    k = KIND_UP;
                            CH_B:    k = KIND_DOWN;
                            CH_C:    k = KIND_RIGHT;
                            CH_D:    k = KIND_LEFT;
                            CH_H:    k = KIND_HOME;
                            CH_F:    k = KIND_END;
                            default: k = KIND_ESC;
                        endcase
                    end else if (intro_q == CH_O && b == CH_H) begin
                        k = KIND_HOME;
                    end else if (intro_q == CH_O && b == CH_F) begin
                        k = KIND_END;
                    end
                    fire = 1'b1;
                    dec_phase = PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (!tmo && b == CH_TILDE) begin
                    if (digit_q == CH_THREE) k = KIND_DELETE;
                    else if (digit_q == CH_FIVE) k = KIND_PAGE_UP;
                    else if (digit_q == CH_SIX) k = KIND_PAGE_DOWN;
                end
                fire = 1'b1;
                dec_phase = PH_IDLE;
            end
            PH_MOUSE: begin
                if (tmo) begin
                    k = close_report(NO_TERM);
                    fire = 1'b1;
                end else begin
                    report_len = report_len + 5'd1;
                    if (b == CH_UPPER_M || b == CH_LOWER_M) begin
                        k = close_report(b);
                        fire = 1'b1;
                    end else begin
                        if (!parse_stop) begin
                            if (b >= CH_ZERO && b <= CH_NINE) begin
                                if (field_sel == 2'd0)
                                    btn_acc = 8'(sat_acc(PTR_W'(btn_acc), d, TYPE_MAX));
                                else if (field_sel == 2'd1)
                                    col_acc = sat_acc(col_acc, d, COORD_MAX);
                                else
                                    row_acc = sat_acc(row_acc, d, COORD_MAX);
                                if (digit_count < 3'd7) digit_count = digit_count + 3'd1;
                            end else if (b == CH_SEMI && digit_count > 3'd0
                                         && field_sel < 2'd2) begin
                                field_sel = field_sel + 2'd1;
                                digit_count = 3'd0;
                            end else begin
                                parse_stop = 1'b1;
                            end
                        end
                        if (int'(report_len) >= REPORT_MAX) begin
                            k = close_report(NO_TERM);
                            fire = 1'b1;
                        end
                    end
                end
                if (fire) dec_phase = PH_IDLE;
            end
            default: begin
                dec_phase = PH_IDLE;
                if (tmo) begin
                    k = KIND_PLAIN;
                    fire = 1'b1;
                end else if (b == CH_ESC) begin
                    dec_phase = PH_ESC;
                end else begin
                    k = KIND_PLAIN;
                    key = b;
                    fire = 1'b1;
                end
            end
        endcase
        ev = '{k, key, ptr_col, ptr_row};
        return fire;
    endfunction

    task automatic send_beat(input bit tmo, input logic [7:0] b, input bit typed,
                             input key_event_t typed_ev);
        key_event_t ev;
        bit         fire;
        if (beats_sent < 620) begin
            send_idle_pct = 35;
            recv_idle_pct = 48;
        end else if (beats_sent < 1240) begin
            send_idle_pct = 48;
            recv_idle_pct = 35;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid      <= 1'b1;
        s_is_timeout <= tmo;
        s_data_byte  <= b;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        fire = decode_beat(tmo, b, ev);
        if (typed) pending_events.push_back(typed_ev);
        else if (fire) pending_events.push_back(ev);
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(1'b0, b, 1'b0, '0);
    endtask

    task automatic send_timeout();
        send_beat(1'b1, 8'($urandom_range(255)), 1'b0, '0);
    endtask

    task automatic send_number(input int n);
        string s;
        s = $sformatf("%0d", n);
        for (int i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_digits(input int cnt);
        for (int i = 0; i < cnt; i++) send_byte(CH_ZERO + 8'($urandom_range(9)));
    endtask

    task automatic send_coord();
        int r;
        r = $urandom_range(99);
        if (r < 70) send_number($urandom_range(300, 1));
        else if (r < 85) send_number($urandom_range(COORD_MAX));
        else if (r < 95) send_digits($urandom_range(9, 5));
        // else no digits
    endtask

    task automatic send_noise();
        int r;
        r = $urandom_range(2);
        if (r == 0) send_byte(8'h20);
        else if (r == 1) send_byte(8'h2D);
        else send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_mouse_report();
        logic [7:0] codes [9];
        int r;
        bit noisy;
        codes = '{BTN_LEFT, BTN_MID, BTN_RIGHT, BTN_LEFT_DRAG, BTN_MID_DRAG,
                  BTN_RIGHT_DRAG, BTN_MOVE, BTN_WHEEL_UP, BTN_WHEEL_DN};
        noisy = ($urandom_range(99) < 10);
        send_byte(CH_ESC);
        send_byte(CH_LBRACK);
        send_byte(CH_LT);
        r = $urandom_range(99);
        if (r < 80) send_number(int'(codes[$urandom_range(8)]));
        else if (r < 88) send_number($urandom_range(TYPE_MAX));
        else if (r < 94) send_digits($urandom_range(5, 4));
        if ($urandom_range(99) < 90) begin
            send_byte(CH_SEMI);
            send_coord();
            if (noisy && $urandom_range(1)) send_noise();
            if ($urandom_range(99) < 85) begin
                send_byte(CH_SEMI);
                send_coord();
            end
        end
        if (noisy) send_noise();
        r = $urandom_range(99);
        if (r < 45) send_byte(CH_UPPER_M);
        else if (r < 80) send_byte(CH_LOWER_M);
        else if (r < 90) send_timeout();
        else send_digits(REPORT_MAX + 1);
    endtask

    task automatic send_sequence();
        logic [7:0] finals [6];
        int r;
        finals = '{CH_A, CH_B, CH_C, CH_D, CH_H, CH_F};
        r = $urandom_range(99);
        if (r < 15) begin
            send_byte(8'($urandom_range(255)));
        end else if (r < 20) begin
            send_timeout();
        end else if (r < 35) begin
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            r = $urandom_range(99);
            if (r < 80) send_byte(finals[$urandom_range(5)]);
            else if (r < 92) send_byte(8'($urandom_range(255)));
            else send_timeout();
        end else if (r < 42) begin
            send_byte(CH_ESC);
            send_byte(CH_O);
            r = $urandom_range(99);
            if (r < 75) send_byte($urandom_range(1) ? CH_H : CH_F);
            else if (r < 90) send_byte(8'($urandom_range(255)));
            else send_timeout();
        end else if (r < 52) begin
            send_byte(CH_ESC);
            send_byte(CH_LBRACK);
            r = $urandom_range(3);
            if (r == 0) send_byte(CH_THREE);
            else if (r == 1) send_byte(CH_FIVE);
            else if (r == 2) send_byte(CH_SIX);
            else send_byte(CH_ZERO + 8'($urandom_range(9)));
            r = $urandom_range(99);
            if (r < 75) send_byte(CH_TILDE);
            else if (r < 90) send_byte(8'($urandom_range(255)));
            else send_timeout();
        end else if (r < 95) begin
            send_mouse_report();
        end else begin
            send_byte(CH_ESC);
            if ($urandom_range(3) == 0) begin
                send_timeout();
            end else begin
                send_byte(8'($urandom_range(255)));
                if ($urandom_range(1)) send_timeout();
                else send_byte(8'($urandom_range(255)));
            end
        end
    endtask

    // output beat checker and receiver stalls
    always @(posedge aclk) begin
        key_event_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t unexpected beat: kind %0d key %0h x %0d y %0d", $time,
                         m_event_kind, m_key_byte, m_pointer_x, m_pointer_y);
                err_count++;
            end else begin
                want = pending_events.pop_front();
                if (m_event_kind !== want.kind) begin
                    $display("%0t event_kind: expected %0d actual %0d", $time,
                             want.kind, m_event_kind);
                    err_count++;
                end
                if (m_key_byte !== want.key) begin
                    $display("%0t key_byte: expected %0h actual %0h", $time,
                             want.key, m_key_byte);
                    err_count++;
                end
                if (m_pointer_x !== want.px) begin
                    $display("%0t pointer_x: expected %0d actual %0d", $time,
                             want.px, m_pointer_x);
                    err_count++;
                end
                if (m_pointer_y !== want.py) begin
                    $display("%0t pointer_y: expected %0d actual %0d", $time,
                             want.py, m_pointer_y);
                    err_count++;
                end
            end
        end
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        err_count     = 0;
        beats_sent    = 0;
        cycle_count   = 0;
        send_idle_pct = 35;
        recv_idle_pct = 48;
        dec_phase     = PH_IDLE;
        intro_q       = 8'd0;
        digit_q       = 8'd0;
        field_sel     = 2'd0;
        digit_count   = 3'd0;
        parse_stop    = 1'b0;
        btn_acc       = 8'd0;
        col_acc       = '0;
        row_acc       = '0;
        report_len    = 5'd0;
        ptr_col       = '0;
        ptr_row       = '0;
        aresetn      <= 1'b0;
        s_valid      <= 1'b0;
        s_is_timeout <= 1'b0;
        s_data_byte  <= 8'd0;
        m_ready      <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(DIR_TAB[i].tmo, DIR_TAB[i].data, DIR_TAB[i].typed, DIR_TAB[i].ev);
        send_byte(CH_UPPER_M);

        while (beats_sent < RAND_BEATS + DIR_ROWS) send_sequence();
        s_valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/tekd_pkg.sv
src/terminal_escape_key_decoder_top.sv
src/tekd_checker.sv
tb/tb_terminal_escape_key_decoder_top.sv
